[rtl/core/gcf_pkg.sv]
// Shared types and constants for the gammatone channel filter.
// No dependencies; every other file of the block imports this package.
package gcf_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int STAGE_COUNT    = 4;
   localparam int DATA_BITS      = 32;
   localparam int COEF_BITS      = 32;
   localparam int CFG_COUNT      = 8;
   localparam int CSR_INDEX_BITS = $clog2(CFG_COUNT);
   localparam int FRAC_BITS      = 30;

   // Bits of the coefficient digit consumed per cycle by the multiplier.
   localparam int DIGIT_BITS     = 8;
   localparam int DIGIT_COUNT    = COEF_BITS / DIGIT_BITS;
   localparam int DIGIT_IDX_BITS = $clog2(DIGIT_COUNT);

   // Terms of one section: b0*x, c*x1, -f1*y1, -f2*y2.
   localparam int TERM_COUNT     = 4;
   localparam int TERM_IDX_BITS  = $clog2(TERM_COUNT);
   localparam int STAGE_IDX_BITS = $clog2(STAGE_COUNT);
   localparam int STEP_BITS      = STAGE_IDX_BITS + TERM_IDX_BITS + DIGIT_IDX_BITS;

   // Multiplicand carries one extra bit so a negated history value fits.
   localparam int MCAND_BITS     = DATA_BITS + 1;
   localparam int PROD_BITS      = MCAND_BITS + DIGIT_BITS + 1;
   localparam int ACC_BITS       = 68;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FIRST_FEED_ZERO  = 3'd0,
      REG_FIRST_FEED_ONE   = 3'd1,
      REG_LATER_FEED_ZERO  = 3'd2,
      REG_SECOND_FEED_ONE  = 3'd3,
      REG_THIRD_FEED_ONE   = 3'd4,
      REG_FOURTH_FEED_ONE  = 3'd5,
      REG_POLE_FEEDBACK_1  = 3'd6,
      REG_POLE_FEEDBACK_2  = 3'd7
   } reg_index_type;

   typedef enum logic [TERM_IDX_BITS-1:0] {
      TERM_FEED_ZERO = 2'd0,
      TERM_FEED_ONE  = 2'd1,
      TERM_POLE_ONE  = 2'd2,
      TERM_POLE_TWO  = 2'd3
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2
   } state_type;

endpackage

[rtl/core/gcf_channels.sv]
// Handshake channels of the gammatone channel filter: sample in, band out, register write.
// Depends on gcf_pkg for field widths.
interface gcf_req_if;
   import gcf_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_in;
   logic                          block_end_in;
   modport source (output valid, output audio_in, output block_end_in, input ready);
   modport sink   (input valid, input audio_in, input block_end_in, output ready);
endinterface

interface gcf_rsp_if;
   import gcf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] band_out;
   logic                        clipped;
   logic                        block_end_out;
   modport source (output valid, output band_out, output clipped, output block_end_out,
                   input ready);
   modport sink   (input valid, input band_out, input clipped, input block_end_out,
                   output ready);
endinterface

interface gcf_csr_if;
   import gcf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_BITS-1:0]   index;
   logic signed [COEF_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/gammatone_channel_filter.sv]
// Top level of one gammatone filterbank channel: four cascaded sections on a shared
// digit-serial multiply-accumulate unit. Depends on gcf_pkg and the gcf channel interfaces.
//
//   channel   direction  word
//   req_ch    in         audio_in, block_end_in
//   rsp_ch    out        band_out, clipped, block_end_out
//   csr_ch    in         index, data (coefficient register write)
//
// Each sample runs 4 sections x 4 terms x 4 coefficient digits of 8 bits, all through
// one 33x9 multiplier and a 68-bit adder, and the result is then handed to the output
// register. The next sample is accepted only after that hand-off, so the block does not
// take a new sample before it is through with the last one.
// A new sample is accepted while the previous result still waits on rsp_ch; the
// finished result waits inside the block until the output register is free.
// Reset clears coefficients, filter history and the handshake state.
module gammatone_channel_filter (
   input logic  clock,
   input logic  reset,
   gcf_req_if.sink   req_ch,
   gcf_rsp_if.source rsp_ch,
   gcf_csr_if.sink   csr_ch
);
   import gcf_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = '1;

   state_type state_ff, state_in;

   logic signed [COEF_BITS-1:0] cfg_ff [CFG_COUNT];

   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [DATA_BITS-1:0]   x_ff, x_in;
   logic signed [DATA_BITS-1:0]   x1_ff, x1_in;
   logic signed [SAMPLE_BITS-1:0] hist_ff;
   logic signed [DATA_BITS-1:0]   y1_ring_ff [STAGE_COUNT];
   logic signed [DATA_BITS-1:0]   y2_ring_ff [STAGE_COUNT];
   logic                          clip_ff, clip_in;
   logic                          end_ff;

   logic signed [DATA_BITS-1:0] rsp_band_ff;
   logic                        rsp_clip_ff;
   logic                        rsp_end_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic req_take;
   logic run_en;
   logic load_out;
   logic out_free;

   logic [STAGE_IDX_BITS-1:0] stage_idx;
   term_type                  term;
   logic [DIGIT_IDX_BITS-1:0] digit_idx;
   logic                      stage_first;
   logic                      stage_last;

   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [MCAND_BITS-1:0]  mcand;
   logic [DIGIT_BITS-1:0]         digit_raw;
   logic signed [DIGIT_BITS:0]    digit;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [ACC_BITS-1:0]    prod_ext;
   logic signed [ACC_BITS-1:0]    prod_aligned;
   logic signed [DATA_BITS-1:0]   y_stage;
   logic                          y_sat;

   logic signed [DATA_BITS-1:0] sample_ext;

   // ---------------------------------------------------------------- control
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      run_en       = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ch.ready = 1'b1;
         ST_RUN:   run_en       = 1'b1;
         ST_DRAIN: load_out     = out_free;
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- config
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) cfg_ff[i] <= '0;
      end else if (csr_ch.valid) begin
         cfg_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   // ---------------------------------------------------------------- datapath
   assign stage_idx   = step_ff[STEP_BITS-1 -: STAGE_IDX_BITS];
   assign term        = term_type'(step_ff[DIGIT_IDX_BITS +: TERM_IDX_BITS]);
   assign digit_idx   = step_ff[DIGIT_IDX_BITS-1:0];
   assign stage_first = (step_ff[TERM_IDX_BITS+DIGIT_IDX_BITS-1:0] == '0);
   assign stage_last  = (step_ff[TERM_IDX_BITS+DIGIT_IDX_BITS-1:0] == '1);

   // Stage one has its own gain-normalised taps; later stages share tap zero.
   always_comb begin
      case (term)
         TERM_FEED_ZERO: begin
            coef_sel = (stage_idx == '0) ? cfg_ff[REG_FIRST_FEED_ZERO]
                                         : cfg_ff[REG_LATER_FEED_ZERO];
            mcand    = MCAND_BITS'(x_ff);
         end
         TERM_FEED_ONE: begin
            case (stage_idx)
               2'd0:    coef_sel = cfg_ff[REG_FIRST_FEED_ONE];
               2'd1:    coef_sel = cfg_ff[REG_SECOND_FEED_ONE];
               2'd2:    coef_sel = cfg_ff[REG_THIRD_FEED_ONE];
               default: coef_sel = cfg_ff[REG_FOURTH_FEED_ONE];
            endcase
            mcand = MCAND_BITS'(x1_ff);
         end
         TERM_POLE_ONE: begin
            coef_sel = cfg_ff[REG_POLE_FEEDBACK_1];
            mcand    = -MCAND_BITS'(y1_ring_ff[0]);
         end
         default: begin
            coef_sel = cfg_ff[REG_POLE_FEEDBACK_2];
            mcand    = -MCAND_BITS'(y2_ring_ff[0]);
         end
      endcase
   end

   // Lower digits are unsigned, the top digit carries the coefficient sign.
   always_comb begin
      digit_raw = coef_sel[digit_idx*DIGIT_BITS +: DIGIT_BITS];
      if (digit_idx == DIGIT_IDX_BITS'(DIGIT_COUNT - 1)) begin
         digit = {digit_raw[DIGIT_BITS-1], digit_raw};
      end else begin
         digit = {1'b0, digit_raw};
      end
      prod         = PROD_BITS'(mcand) * PROD_BITS'(digit);
      prod_ext     = ACC_BITS'(prod);
      prod_aligned = prod_ext <<< (digit_idx * DIGIT_BITS);
   end

   always_comb begin
      if (stage_first) begin
         acc_in = ROUND_HALF + prod_aligned;
      end else begin
         acc_in = acc_ff + prod_aligned;
      end
   end

   // The shifted sum fits 32 bits when every bit above bit 61 matches bit 61.
   always_comb begin
      y_sat = (acc_in[ACC_BITS-1:FRAC_BITS+DATA_BITS-1] != '0) &&
              (acc_in[ACC_BITS-1:FRAC_BITS+DATA_BITS-1] != '1);
      if (!y_sat) begin
         y_stage = acc_in[FRAC_BITS+DATA_BITS-1:FRAC_BITS];
      end else if (acc_in[ACC_BITS-1]) begin
         y_stage = {1'b1, {(DATA_BITS-1){1'b0}}};
      end else begin
         y_stage = {1'b0, {(DATA_BITS-1){1'b1}}};
      end
   end

   assign sample_ext = DATA_BITS'(req_ch.audio_in);

   always_comb begin
      step_in = step_ff;
      x_in    = x_ff;
      x1_in   = x1_ff;
      clip_in = clip_ff;
      if (req_take) begin
         step_in = '0;
         x_in    = sample_ext;
         x1_in   = DATA_BITS'(hist_ff);
         clip_in = 1'b0;
      end else if (run_en) begin
         step_in = step_ff + 1'b1;
         if (stage_last) begin
            // Next section sees this output and the old y1 of this section.
            x_in    = y_stage;
            x1_in   = y1_ring_ff[0];
            clip_in = clip_ff | y_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         clip_ff <= 1'b0;
         hist_ff <= '0;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            y1_ring_ff[i] <= '0;
            y2_ring_ff[i] <= '0;
         end
      end else begin
         step_ff <= step_in;
         clip_ff <= clip_in;
         if (req_take) hist_ff <= req_ch.audio_in;
         // The section histories rotate so that the active section sits at the head.
         if (run_en && stage_last) begin
            for (int i = 0; i < STAGE_COUNT - 1; i++) begin
               y1_ring_ff[i] <= y1_ring_ff[i+1];
               y2_ring_ff[i] <= y2_ring_ff[i+1];
            end
            y1_ring_ff[STAGE_COUNT-1] <= y_stage;
            y2_ring_ff[STAGE_COUNT-1] <= y1_ring_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      x1_ff  <= x1_in;
      if (req_take) end_ff <= req_ch.block_end_in;
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_band_ff <= x_ff;
         rsp_clip_ff <= clip_ff;
         rsp_end_ff  <= end_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.band_out      = rsp_band_ff;
   assign rsp_ch.clipped       = rsp_clip_ff;
   assign rsp_ch.block_end_out = rsp_end_ff;

endmodule
